// ----- src/dtsp_pkg.sv -----
`default_nettype none
package dtsp_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned PATTERN_W = 24;
    localparam int unsigned REM_W     = 10;   // remainder below 1000
    localparam int unsigned TENS_W    = 7;    // remainder below 100

    localparam logic [VALUE_W-1:0] LIMIT_VALUE = 16'd2000;
    localparam logic [10:0]        THOUSAND    = 11'd1000;

    localparam logic [6:0] SEG_E = 7'b1111001;
    localparam logic [6:0] SEG_R = 7'b1010000;

    // Digits of one value, passed from the splitter to the encoder
    typedef struct packed {
        logic       overflow;
        logic       thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // gfedcba code of one decimal digit
    function automatic logic [6:0] digit_code(input logic [3:0] d);
        logic [6:0] code;
        case (d)
            4'd0:    code = 7'b0111111;
            4'd1:    code = 7'b0000110;
            4'd2:    code = 7'b1011011;
            4'd3:    code = 7'b1001111;
            4'd4:    code = 7'b1100110;
            4'd5:    code = 7'b1101101;
            4'd6:    code = 7'b1111101;
            4'd7:    code = 7'b0000111;
            4'd8:    code = 7'b1111111;
            4'd9:    code = 7'b1101111;
            default: code = 7'b0000000;
        endcase
        return code;
    endfunction

    function automatic logic [PATTERN_W-1:0] place_hundreds(input logic [6:0] seg);
        logic [PATTERN_W-1:0] p;
        p      = '0;
        p[7:2] = seg[5:0];
        p[8]   = seg[6];
        return p;
    endfunction

    function automatic logic [PATTERN_W-1:0] place_tens(input logic [6:0] seg);
        logic [PATTERN_W-1:0] p;
        p       = '0;
        p[15:9] = seg;
        return p;
    endfunction

    function automatic logic [PATTERN_W-1:0] place_units(input logic [6:0] seg);
        logic [PATTERN_W-1:0] p;
        p        = '0;
        p[23:17] = seg;
        return p;
    endfunction

    localparam logic [PATTERN_W-1:0] ERR_PATTERN =
        place_hundreds(SEG_E) | place_tens(SEG_R) | place_units(SEG_R);

endpackage
`default_nettype wire

// ----- src/dtsp_digits.sv -----
`default_nettype none
// Split a value below 2000 into decimal digits with parallel compare ladders.
module dtsp_digits (
    input  wire logic [dtsp_pkg::VALUE_W-1:0] value,
    output dtsp_pkg::digits_t                 digits
);

    logic [10:0]                  low_bits;
    logic                         thousands;
    logic [dtsp_pkg::REM_W-1:0]   rem_h;
    logic [3:0]                   hundreds;
    logic [dtsp_pkg::REM_W-1:0]   hundreds_base;
    logic [dtsp_pkg::REM_W-1:0]   rem_t_full;
    logic [dtsp_pkg::TENS_W-1:0]  rem_t;
    logic [3:0]                   tens;
    logic [dtsp_pkg::TENS_W-1:0]  tens_base;
    logic [dtsp_pkg::TENS_W-1:0]  rem_u;

    assign low_bits  = value[10:0];
    assign thousands = (low_bits >= dtsp_pkg::THOUSAND);
    assign rem_h     = thousands ? dtsp_pkg::REM_W'(low_bits - dtsp_pkg::THOUSAND)
                                 : low_bits[dtsp_pkg::REM_W-1:0];

    always_comb
    begin
        hundreds      = 4'd0;
        hundreds_base = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_h >= dtsp_pkg::REM_W'(k * 100))
            begin
                hundreds      = 4'(k);
                hundreds_base = dtsp_pkg::REM_W'(k * 100);
            end
        end
    end

    assign rem_t_full = rem_h - hundreds_base;
    assign rem_t      = rem_t_full[dtsp_pkg::TENS_W-1:0];

    always_comb
    begin
        tens      = 4'd0;
        tens_base = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem_t >= dtsp_pkg::TENS_W'(k * 10))
            begin
                tens      = 4'(k);
                tens_base = dtsp_pkg::TENS_W'(k * 10);
            end
        end
    end

    assign rem_u = rem_t - tens_base;

    assign digits.overflow  = (value >= dtsp_pkg::LIMIT_VALUE);
    assign digits.thousands = thousands;
    assign digits.hundreds  = hundreds;
    assign digits.tens      = tens;
    assign digits.units     = rem_u[3:0];

endmodule
`default_nettype wire

// ----- src/dtsp_encode.sv -----
`default_nettype none
// Map digits onto the display's segment layout, blanking leading zeros unless show_zeros is set; overflow shows Err.
module dtsp_encode (
    input  wire dtsp_pkg::digits_t              digits,
    input  wire logic                           show_zeros,
    output logic [dtsp_pkg::PATTERN_W-1:0]      segment_pattern
);

    logic blank_hundreds;
    logic blank_tens;

    assign blank_hundreds = !show_zeros && !digits.thousands && (digits.hundreds == 4'd0);
    assign blank_tens     = blank_hundreds && (digits.tens == 4'd0);

    always_comb
    begin
        if (digits.overflow)
        begin
            segment_pattern = dtsp_pkg::ERR_PATTERN;
        end
        else
        begin
            segment_pattern = dtsp_pkg::place_units(dtsp_pkg::digit_code(digits.units));
            if (digits.thousands)
            begin
                segment_pattern[1:0] = 2'b11;
            end
            if (!blank_hundreds)
            begin
                segment_pattern = segment_pattern |
                    dtsp_pkg::place_hundreds(dtsp_pkg::digit_code(digits.hundreds));
            end
            if (!blank_tens)
            begin
                segment_pattern = segment_pattern |
                    dtsp_pkg::place_tens(dtsp_pkg::digit_code(digits.tens));
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/decimal_to_seven_segment_pattern.sv -----
`default_nettype none
// Decimal to seven-segment pattern for a 3.5-digit display.
//
// Command channel: drive value and show_zeros with start high; the beat is
// taken at any rising edge where start is high and busy is low. busy is
// always low, so a new beat may be issued in every cycle.
// Result channel: segment_pattern and overflow are valid for exactly one
// cycle while done is high. Values of 2000 or more show Err on digits 2..4
// and raise overflow; otherwise the value is shown in decimal, leading
// zeros blanked unless show_zeros keeps the hundreds and tens digits.
//
// Path: a taken beat lands in the input register, then the result register
// loads from it, and done rises together with the loaded result.
// Throughput: one beat per cycle, set by the two-register path (input
// register, digit split and segment encode, result register).
// Reset: rst_n clears both valid flags, dropping any beat in flight; no
// done strobe follows until a new beat is taken.
// The receiver cannot stall: each result appears for one cycle only.
module decimal_to_seven_segment_pattern (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [dtsp_pkg::VALUE_W-1:0]     value,
    input  wire logic                             show_zeros,
    output logic                                  done,
    output logic [dtsp_pkg::PATTERN_W-1:0]        segment_pattern,
    output logic                                  overflow
);

    logic                               accept;
    logic                               in_valid_reg;
    logic [dtsp_pkg::VALUE_W-1:0]       value_reg;
    logic                               show_zeros_reg;
    logic                               done_reg;
    logic [dtsp_pkg::PATTERN_W-1:0]     segment_pattern_reg;
    logic [dtsp_pkg::PATTERN_W-1:0]     segment_pattern_next;
    logic                               overflow_reg;
    dtsp_pkg::digits_t                  digits;

    // Never hold off a beat: the datapath takes one every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // Input register: capture the command beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg      <= value;
            show_zeros_reg <= show_zeros;
        end
    end

    dtsp_digits u_digits (
        .value  (value_reg),
        .digits (digits)
    );

    dtsp_encode u_encode (
        .digits          (digits),
        .show_zeros      (show_zeros_reg),
        .segment_pattern (segment_pattern_next)
    );

    // Result register: advance only when a beat sits in the input register
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            segment_pattern_reg <= segment_pattern_next;
            overflow_reg        <= digits.overflow;
        end
    end

    assign done            = done_reg;
    assign segment_pattern = segment_pattern_reg;
    assign overflow        = overflow_reg;

    // Every accepted beat yields a strobe once it has passed the input and result registers
    a_beat_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted beat produced no result strobe");

    // Overflow results always show Err
    a_err_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (segment_pattern == dtsp_pkg::ERR_PATTERN))
        else $error("overflow result does not show Err");

    // In-range results keep the decimal point dark and always show units
    a_units_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !overflow) |-> (!segment_pattern[16] && (segment_pattern[23:17] != 7'd0)))
        else $error("in-range result lost its units digit");

endmodule
`default_nettype wire
